/* rtl/prqs_pkg.sv */
// ============================================================================
// prqs_pkg: shared types and codes for the priority ready queue
// Entry layout, command codes and result status codes.
// ============================================================================
package prqs_pkg;

    localparam int ID_W   = 8;
    localparam int PRIO_W = 8;
    localparam int TIME_W = 16;

    // command carried in the input tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    // Entry, id in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] done;
        logic [TIME_W-1:0] needed;
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_SELECTED = 2'd2,
        STAT_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic    now_empty;
        t_entry  entry;
        t_status status;
    } t_result;

endpackage

/* rtl/priority_ready_queue_select_top.sv */
// ============================================================================
// priority_ready_queue_select_top: priority ready queue with select
// Arrival-ordered store of process entries; select removes the best one.
// ============================================================================
// The queue keeps up to QUEUE_DEPTH entries in arrival order in one
// synchronous RAM. An insert beat (tuser = 0) appends at the tail, or
// reports full. A select beat (tuser = 1) scans the RAM one entry per cycle
// for the highest priority, breaking ties on the smallest needed - done
// (signed) and then on arrival order, then closes the gap by moving each
// later entry down one slot, again one per cycle. An insert, or a select on
// an empty queue, is answered straight from ST_IDLE with no scan.
// The RAM's single read port sets both passes. A result sits in the output
// register and a second one can wait behind it, so the next beat is taken
// while an earlier result is still unclaimed.
// No clearing pass: only slots below the entry count are ever read.
// ============================================================================
module priority_ready_queue_select_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] proc_id, [15:8] prio_level, [31:16] service_needed,
    // [47:32] service_done
    input  logic [47:0] i_s_tdata,
    // [0] cmd
    input  logic        i_s_tuser,
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] out_id, [15:8] out_prio, [31:16] out_needed, [47:32] out_done,
    // [48] now_empty, [55:49] zero
    output logic [55:0] o_m_tdata,
    // [1:0] result_status
    output logic [1:0]  o_m_tuser
);
    import prqs_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_idx, n_idx;       // scan: slot in rd data; shift: write slot
    t_entry              r_best, n_best;
    logic [AW-1:0]       r_best_idx, n_best_idx;
    logic signed [16:0]  r_best_rem, n_best_rem;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;
    t_result             r_pend, n_pend;
    logic                r_pend_valid, n_pend_valid;

    // RAM port
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    t_entry        wr_data, rd_data;

    // work result of this cycle
    logic    fin;
    t_result fin_res;

    logic               accept, out_free, take, last;
    t_entry             in_entry;
    logic signed [16:0] cand_rem;
    logic [CW-1:0]      idx_ext, count_m1;
    logic [CW:0]        shift_next;

    prqs_entry_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_s_tready = (r_state == ST_IDLE) && !r_pend_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign in_entry   = t_entry'(i_s_tdata);

    assign idx_ext    = CW'(r_idx);
    assign count_m1   = r_count - CW'(1);
    assign shift_next = {1'b0, idx_ext} + (CW + 1)'(2);
    assign cand_rem   = $signed({1'b0, rd_data.needed}) - $signed({1'b0, rd_data.done});

    // scan compare: first slot seeds the best; later slots must strictly win
    always_comb begin
        take = (r_idx == '0) ||
               (rd_data.prio > r_best.prio) ||
               ((rd_data.prio == r_best.prio) && (cand_rem < r_best_rem));
        last = (idx_ext == count_m1);
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_best_rem   = r_best_rem;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = rd_data;
        fin          = 1'b0;
        fin_res      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_s_tuser == CMD_INSERT) begin
                        fin = 1'b1;
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            fin_res.status    = STAT_FULL;
                            fin_res.now_empty = (r_count == '0);
                        end else begin
                            wr_en             = 1'b1;
                            wr_addr           = r_count[AW-1:0];
                            wr_data           = in_entry;
                            n_count           = r_count + CW'(1);
                            fin_res.status    = STAT_INSERTED;
                            fin_res.now_empty = 1'b0;
                        end
                    end else if (r_count == '0) begin
                        fin               = 1'b1;
                        fin_res.status    = STAT_EMPTY;
                        fin_res.now_empty = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (take) begin
                    n_best     = rd_data;
                    n_best_idx = r_idx;
                    n_best_rem = cand_rem;
                end
                if (last) begin
                    if (CW'(n_best_idx) == count_m1) begin
                        // winner at the tail: nothing to move
                        fin               = 1'b1;
                        fin_res.status    = STAT_SELECTED;
                        fin_res.entry     = n_best;
                        fin_res.now_empty = (r_count == CW'(1));
                        n_count           = count_m1;
                        n_state           = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = n_best_idx + AW'(1);
                        n_idx   = n_best_idx;
                        n_state = ST_SHIFT;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end

            ST_SHIFT: begin
                // rd data holds slot r_idx + 1; move it down
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = rd_data;
                if (shift_next < {1'b0, r_count}) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + AW'(2);
                    n_idx   = r_idx + AW'(1);
                end else begin
                    fin               = 1'b1;
                    fin_res.status    = STAT_SELECTED;
                    fin_res.entry     = r_best;
                    fin_res.now_empty = (r_count == CW'(1));
                    n_count           = count_m1;
                    n_state           = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register plus one waiting result behind it
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (r_pend_valid && out_free) begin
            n_out        = r_pend;
            n_out_valid  = 1'b1;
            n_pend_valid = 1'b0;
        end
        if (fin) begin
            if (out_free) begin
                n_out       = fin_res;
                n_out_valid = 1'b1;
            end else begin
                n_pend       = fin_res;
                n_pend_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_rem <= n_best_rem;
        r_out      <= n_out;
        r_pend     <= n_pend;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out.now_empty, r_out.entry};
    assign o_m_tuser  = r_out.status;

endmodule

/* rtl/prqs_entry_ram.sv */
// ============================================================================
// prqs_entry_ram: entry store
// One write port, one read port, read data registered.
// ============================================================================
module prqs_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  prqs_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output prqs_pkg::t_entry o_rd_data
);
    import prqs_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
